// ===== rtl/bbf_pkg.sv =====
package bbf_pkg;

    localparam int LOG_MAX_BLOCKS = 10;
    localparam int WORD_W         = 64;
    localparam int BANKS          = 4;
    localparam int BANK_W         = 2;
    localparam int ROW_W          = LOG_MAX_BLOCKS;
    localparam int ROWS           = 1 << ROW_W;
    localparam int POS_W          = 6;
    localparam int CMD_W          = 3;
    localparam int IDX_W          = 12;
    localparam int HASH_W         = 64;
    localparam int CFG_W          = 4;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = 1;
    localparam int QCNT_W         = 2;

    localparam logic [CFG_W-1:0] LOG_BLOCKS_RESET = CFG_W'(LOG_MAX_BLOCKS);

    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MERGE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

    typedef enum logic [2:0] {
        OP_INSERT,
        OP_QUERY,
        OP_CLEAR,
        OP_MERGE,
        OP_READ,
        OP_ERROR,
        OP_NONE
    } t_op;

    typedef struct packed {
        t_op                             op;
        logic [ROW_W-1:0]                row;
        logic [BANK_W-1:0]               bank;
        logic [BANKS-1:0][POS_W-1:0]     pos;
        logic [WORD_W-1:0]               value;
    } t_job;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_RESP
    } t_state;

endpackage

// ===== rtl/bbf_front.sv =====
module bbf_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [bbf_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [bbf_pkg::CMD_W-1:0] i_cmd,
    input  logic [bbf_pkg::HASH_W-1:0] i_hash,
    input  logic [bbf_pkg::IDX_W-1:0] i_word_index,
    input  logic [bbf_pkg::WORD_W-1:0] i_word_value,
    input  logic                      i_full,
    input  logic                      i_init,
    output logic                      o_push,
    output bbf_pkg::t_job             o_job
);
    import bbf_pkg::*;

    logic [CFG_W-1:0] r_log;
    logic [CFG_W-1:0] act_log;
    logic [ROW_W-1:0] blk_mask;
    logic [ROW_W-1:0] idx_row;
    logic             out_of_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log <= LOG_BLOCKS_RESET;
        end else if (i_cfg_we) begin
            r_log <= i_cfg_data;
        end
    end

    always_comb begin
        act_log      = (r_log > CFG_W'(LOG_MAX_BLOCKS)) ? CFG_W'(LOG_MAX_BLOCKS) : r_log;
        blk_mask     = ROW_W'(((ROW_W+1)'(1) << act_log) - (ROW_W+1)'(1));
        idx_row      = i_word_index[IDX_W-1:BANK_W];
        out_of_range = (idx_row & ~blk_mask) != '0;

        o_job.value = i_word_value;
        o_job.bank  = i_word_index[BANK_W-1:0];
        for (int k = 0; k < BANKS; k++) begin
            o_job.pos[k] = i_hash[32 + 8*k +: POS_W];
        end

        unique case (i_cmd)
            CMD_INSERT: begin
                o_job.op  = OP_INSERT;
                o_job.row = i_hash[ROW_W-1:0] & blk_mask;
            end
            CMD_QUERY: begin
                o_job.op  = OP_QUERY;
                o_job.row = i_hash[ROW_W-1:0] & blk_mask;
            end
            CMD_CLEAR: begin
                o_job.op  = OP_CLEAR;
                o_job.row = idx_row;
            end
            CMD_MERGE: begin
                o_job.op  = out_of_range ? OP_ERROR : OP_MERGE;
                o_job.row = idx_row;
            end
            CMD_READ: begin
                o_job.op  = out_of_range ? OP_ERROR : OP_READ;
                o_job.row = idx_row;
            end
            default: begin
                o_job.op  = OP_NONE;
                o_job.row = idx_row;
            end
        endcase
    end

    assign o_stall = i_full | i_init;
    assign o_push  = i_valid & ~o_stall;

endmodule

// ===== rtl/bbf_queue.sv =====
module bbf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bbf_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output bbf_pkg::t_job o_job
);
    import bbf_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_pop;

    assign o_full  = r_count == QCNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_job   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(do_pop);
        end
    end

endmodule

// ===== rtl/bbf_back.sv =====
module bbf_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_job_valid,
    input  bbf_pkg::t_job              i_job,
    output logic                       o_pop,
    output logic                       o_init,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_match,
    output logic [bbf_pkg::WORD_W-1:0] o_read_value,
    output logic                       o_nonempty,
    output logic                       o_status
);
    import bbf_pkg::*;

    t_state                        r_state;
    t_state                        n_state;
    logic [ROW_W-1:0]              r_cnt;
    logic                          r_init;
    t_job                          r_job;
    logic                          r_has;
    logic                          r_match;
    logic [WORD_W-1:0]             r_rd;
    logic                          r_status;

    logic [BANKS-1:0][WORD_W-1:0]  rdata;
    logic [BANKS-1:0]              mem_we;
    logic [ROW_W-1:0]              mem_wa;
    logic [BANKS-1:0][WORD_W-1:0]  mem_wd;
    logic [ROW_W-1:0]              mem_ra;
    logic                          sweep_done;
    logic                          all_set;

    assign sweep_done = r_cnt == ROW_W'(ROWS - 1);

    always_comb begin
        all_set = 1'b1;
        for (int k = 0; k < BANKS; k++) begin
            all_set = all_set & rdata[k][r_job.pos[k]];
        end
    end

    for (genvar k = 0; k < BANKS; k++) begin : g_bank
        logic [WORD_W-1:0] r_mem [ROWS];
        logic [WORD_W-1:0] r_q;
        always_ff @(posedge i_clk) begin
            if (mem_we[k]) begin
                r_mem[mem_wa] <= mem_wd[k];
            end
            r_q <= r_mem[mem_ra];
        end
        assign rdata[k] = r_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        mem_we  = '0;
        mem_wa  = r_job.row;
        mem_wd  = '0;
        mem_ra  = i_job.row;
        unique case (r_state)
            S_CLEAR: begin
                mem_we = '1;
                mem_wa = r_cnt;
                if (sweep_done) begin
                    n_state = r_init ? S_IDLE : S_RESP;
                end
            end
            S_IDLE: begin
                if (i_job_valid) begin
                    o_pop = 1'b1;
                    unique case (i_job.op)
                        OP_INSERT, OP_QUERY, OP_MERGE, OP_READ: n_state = S_READ;
                        OP_CLEAR:                               n_state = S_CLEAR;
                        default:                                n_state = S_RESP;
                    endcase
                end
            end
            S_READ: begin
                n_state = S_RESP;
                if (r_job.op == OP_INSERT) begin
                    mem_we = '1;
                    for (int k = 0; k < BANKS; k++) begin
                        mem_wd[k] = rdata[k] | (WORD_W'(1) << r_job.pos[k]);
                    end
                end else if (r_job.op == OP_MERGE) begin
                    mem_we[r_job.bank] = 1'b1;
                    mem_wd[r_job.bank] = rdata[r_job.bank] | r_job.value;
                end
            end
            S_RESP: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_init <= 1'b1;
            r_has  <= 1'b0;
        end else begin
            if (r_state == S_CLEAR) begin
                r_cnt <= r_cnt + ROW_W'(1);
                if (sweep_done) begin
                    r_init <= 1'b0;
                end
            end
            if (o_pop && i_job.op == OP_INSERT) begin
                r_has <= 1'b1;
            end else if (o_pop && i_job.op == OP_CLEAR) begin
                r_has <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job    <= i_job;
            r_match  <= 1'b0;
            r_rd     <= '0;
            r_status <= i_job.op == OP_ERROR;
        end else if (r_state == S_READ) begin
            if (r_job.op == OP_QUERY) begin
                r_match <= all_set;
            end
            if (r_job.op == OP_READ) begin
                r_rd <= rdata[r_job.bank];
            end
        end
    end

    assign o_init       = r_init;
    assign o_valid      = r_state == S_RESP;
    assign o_match      = r_match;
    assign o_read_value = r_rd;
    assign o_nonempty   = r_has;
    assign o_status     = r_status;

    a_no_work_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |-> !i_job_valid)
        else $error("queue holds a transaction during the reset sweep");

    a_status_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (o_read_value == '0 && !o_match))
        else $error("error transaction carries data");

    a_insert_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_job.op == OP_INSERT) |-> o_nonempty)
        else $error("insert result not marked non-empty");

    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_job.op == OP_CLEAR) |-> !o_nonempty)
        else $error("clear result still marked non-empty");

    a_sweep_from_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && !r_init) |-> r_job.op == OP_CLEAR)
        else $error("sweep running without a clear transaction");

endmodule

// ===== rtl/blocked_bloom_filter.sv =====
// Blocked Bloom filter over 256-bit blocks of four 64-bit words.
// Input channel: i_valid/o_stall with i_cmd, i_hash, i_word_index and
// i_word_value; a transaction is taken at a rising edge with i_valid high
// and o_stall low. Output channel: o_valid/i_stall with o_match,
// o_read_value, o_nonempty and o_status; one result per transaction, in order.
// i_cfg_we/i_cfg_data write log2 of the blocks in use (reset 10); write it
// only while no transaction is outstanding.
// A two-entry queue parts the decoder from the execution unit. The store is
// four banks of 1024 words, one per word of a block, each with one write and
// one registered read port. Insert, query, merge and read pass through the
// execution unit in order: pick up from the queue, bank read, result.
// Out-of-range and unused commands go from pick up straight to the result.
// Clear sweeps all 1024 rows of the banks, then shows its result.
// After reset the same sweep zeroes the store; o_stall stays high
// until it ends. While i_stall is high the result holds on the outputs, the
// queue keeps filling and o_stall rises once it is full.
module blocked_bloom_filter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bbf_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [bbf_pkg::CMD_W-1:0]   i_cmd,
    input  logic [bbf_pkg::HASH_W-1:0]  i_hash,
    input  logic [bbf_pkg::IDX_W-1:0]   i_word_index,
    input  logic [bbf_pkg::WORD_W-1:0]  i_word_value,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_match,
    output logic [bbf_pkg::WORD_W-1:0]  o_read_value,
    output logic                        o_nonempty,
    output logic                        o_status
);
    import bbf_pkg::*;

    t_job push_job;
    t_job head_job;
    logic push;
    logic q_full;
    logic q_valid;
    logic pop;
    logic init;

    bbf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_hash       (i_hash),
        .i_word_index (i_word_index),
        .i_word_value (i_word_value),
        .i_full       (q_full),
        .i_init       (init),
        .o_push       (push),
        .o_job        (push_job)
    );

    bbf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    bbf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (q_valid),
        .i_job        (head_job),
        .o_pop        (pop),
        .o_init       (init),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_match      (o_match),
        .o_read_value (o_read_value),
        .o_nonempty   (o_nonempty),
        .o_status     (o_status)
    );

endmodule

// ===== test/testbench.sv =====
module testbench;
    import bbf_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int STORE_WORDS = BANKS * ROWS;
    localparam int KEEP_KEYS   = 48;
    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = CMD_W'(CMD_READ + 1);
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = {CMD_W{1'b1}};

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [HASH_W-1:0] hash;
        logic [IDX_W-1:0]  index;
        logic [WORD_W-1:0] value;
    } filter_cmd_t;

    typedef struct {
        logic              match;
        logic [WORD_W-1:0] read_value;
        logic              nonempty;
        logic              status;
    } filter_resp_t;

    class bloom_scoreboard;
        logic [WORD_W-1:0] shadow_store [STORE_WORDS];
        logic              shadow_nonempty;
        logic [CFG_W-1:0]  log_blocks;
        filter_resp_t      awaited [$];
        int                errors;
        int                checked;
        int                hits;
        int                range_errors;
        int                clears;

        function new();
            foreach (shadow_store[i]) shadow_store[i] = '0;
            shadow_nonempty = 1'b0;
            log_blocks      = LOG_BLOCKS_RESET;
            errors          = 0;
            checked         = 0;
            hits            = 0;
            range_errors    = 0;
            clears          = 0;
        endfunction

        function void set_log_blocks(logic [CFG_W-1:0] v);
            log_blocks = v;
        endfunction

        function int active_log();
            return (log_blocks > LOG_MAX_BLOCKS) ? LOG_MAX_BLOCKS : int'(log_blocks);
        endfunction

        function int words_in_use();
            return BANKS << active_log();
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void note_input(filter_cmd_t c);
            filter_resp_t r;
            int           base;
            int           pos;
            r.match      = 1'b0;
            r.read_value = '0;
            r.status     = 1'b0;
            base = (int'(c.hash[ROW_W-1:0]) & ((1 << active_log()) - 1)) * BANKS;
            case (c.cmd)
                CMD_INSERT: begin
                    for (int k = 0; k < BANKS; k++) begin
                        pos = int'(c.hash[HASH_W/2 + 8*k +: POS_W]);
                        shadow_store[base + k][pos] = 1'b1;
                    end
                    shadow_nonempty = 1'b1;
                end
                CMD_QUERY: begin
                    r.match = 1'b1;
                    for (int k = 0; k < BANKS; k++) begin
                        pos = int'(c.hash[HASH_W/2 + 8*k +: POS_W]);
                        if (!shadow_store[base + k][pos]) r.match = 1'b0;
                    end
                end
                CMD_CLEAR: begin
                    foreach (shadow_store[i]) shadow_store[i] = '0;
                    shadow_nonempty = 1'b0;
                    clears++;
                end
                CMD_MERGE: begin
                    if (int'(c.index) >= words_in_use()) r.status = 1'b1;
                    else shadow_store[c.index] = shadow_store[c.index] | c.value;
                end
                CMD_READ: begin
                    if (int'(c.index) >= words_in_use()) r.status = 1'b1;
                    else r.read_value = shadow_store[c.index];
                end
                default: ;
            endcase
            r.nonempty = shadow_nonempty;
            if (r.match) hits++;
            if (r.status) range_errors++;
            awaited.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40) $display("mismatch: %s", msg);
        endtask

        task check_result(filter_resp_t got);
            filter_resp_t want;
            if (awaited.size() == 0) begin
                report("result arrived with no transaction outstanding");
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (got.match !== want.match)
                report($sformatf("result %0d: match %b, expected %b",
                                 checked, got.match, want.match));
            if (got.read_value !== want.read_value)
                report($sformatf("result %0d: read_value %h, expected %h",
                                 checked, got.read_value, want.read_value));
            if (got.nonempty !== want.nonempty)
                report($sformatf("result %0d: nonempty %b, expected %b",
                                 checked, got.nonempty, want.nonempty));
            if (got.status !== want.status)
                report($sformatf("result %0d: status %b, expected %b",
                                 checked, got.status, want.status));
        endtask
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CFG_W-1:0]  i_cfg_data;
    logic              i_valid;
    logic              o_stall;
    logic [CMD_W-1:0]  i_cmd;
    logic [HASH_W-1:0] i_hash;
    logic [IDX_W-1:0]  i_word_index;
    logic [WORD_W-1:0] i_word_value;
    logic              o_valid;
    logic              i_stall;
    logic              o_match;
    logic [WORD_W-1:0] o_read_value;
    logic              o_nonempty;
    logic              o_status;

    bloom_scoreboard   sb = new();
    logic [HASH_W-1:0] keys [$];
    int                sent;
    int                settings;

    blocked_bloom_filter u_top (.*);

    initial i_clk = 1'b0;
    always #(CLK_PERIOD/2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(filter_resp_t'{o_match, o_read_value, o_nonempty, o_status});
    end

    initial begin
        int mode;
        int span;
        i_stall = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 150);
            repeat (span) begin
                @(negedge i_clk);
                case (mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 99) < 25);
                    2: i_stall <= ($urandom_range(0, 99) < 75);
                    default: i_stall <= ~i_stall;
                endcase
            end
        end
    end

    initial begin
        #(CLK_PERIOD * 600000);
        $display("testbench NOT OK");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic filter_cmd_t make_cmd(logic [CMD_W-1:0] cmd, logic [HASH_W-1:0] hash,
                                             logic [IDX_W-1:0] index,
                                             logic [WORD_W-1:0] value);
        filter_cmd_t c;
        c.cmd   = cmd;
        c.hash  = hash;
        c.index = index;
        c.value = value;
        return c;
    endfunction

    task automatic send(filter_cmd_t c);
        i_valid      <= 1'b1;
        i_cmd        <= c.cmd;
        i_hash       <= c.hash;
        i_word_index <= c.index;
        i_word_value <= c.value;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(c);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic pause(int cycles);
        i_valid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic drain_and_configure(logic [CFG_W-1:0] v);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        sb.set_log_blocks(v);
        settings++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int count);
        filter_cmd_t c;
        int          pick;
        int          burst;
        burst = 0;
        for (int n = 0; n < count; n++) begin
            c = make_cmd(CMD_W'($urandom), rand64(), IDX_W'($urandom), rand64());
            pick = $urandom_range(0, 999);
            if (pick < 300) begin
                c.cmd = CMD_INSERT;
                if (keys.size() != 0 && $urandom_range(0, 3) == 0) begin
                    c.hash = keys[$urandom_range(0, keys.size() - 1)];
                end else begin
                    keys.push_back(c.hash);
                    if (keys.size() > KEEP_KEYS) void'(keys.pop_front());
                end
            end else if (pick < 600) begin
                c.cmd = CMD_QUERY;
                if (keys.size() != 0 && pick < 480)
                    c.hash = keys[$urandom_range(0, keys.size() - 1)];
                else if (keys.size() != 0 && pick < 530)
                    c.hash = {keys[$urandom_range(0, keys.size() - 1)][63:32], c.hash[31:0]};
            end else if (pick < 760) begin
                c.cmd = CMD_READ;
                if ($urandom_range(0, 9) != 0)
                    c.index = IDX_W'($urandom_range(0, sb.words_in_use() - 1));
            end else if (pick < 920) begin
                c.cmd = CMD_MERGE;
                if ($urandom_range(0, 9) != 0)
                    c.index = IDX_W'($urandom_range(0, sb.words_in_use() - 1));
                if ($urandom_range(0, 1) == 0)
                    c.value = 64'd1 << $urandom_range(0, 63);
            end else if (pick < 935) begin
                c.cmd = CMD_CLEAR;
            end else begin
                c.cmd = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
            end
            if (burst == 0) begin
                pause($urandom_range(1, 6));
                burst = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(1, 12);
            end
            burst--;
            send(c);
        end
    endtask

    initial begin
        logic [CFG_W-1:0] phase_log [8];
        phase_log    = '{4'd10, 4'd0, 4'd2, 4'd15, 4'd5, 4'd11, 4'd1, 4'd10};
        sent         = 0;
        settings     = 1;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = LOG_BLOCKS_RESET;
        i_valid      = 1'b0;
        i_cmd        = CMD_INSERT;
        i_hash       = '0;
        i_word_index = '0;
        i_word_value = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send(make_cmd(CMD_QUERY,  '0, '0, '0));
        send(make_cmd(CMD_READ,   '0, '0, '0));
        send(make_cmd(CMD_INSERT, '1, '0, '0));
        send(make_cmd(CMD_QUERY,  '1, '0, '0));
        send(make_cmd(CMD_INSERT, '0, '1, '1));
        send(make_cmd(CMD_QUERY,  '0, '0, '0));
        send(make_cmd(CMD_READ,   '0, '1, '0));
        send(make_cmd(CMD_READ,   '0, '0, '1));
        send(make_cmd(CMD_MERGE,  '0, '1, '1));
        send(make_cmd(CMD_READ,   '0, '1, '0));
        send(make_cmd(CMD_MERGE,  '0, 12'd1, 64'h8000_0000_0000_0001));
        send(make_cmd(CMD_READ,   '0, 12'd1, '0));
        send(make_cmd(CMD_UNUSED_LO, '1, '1, '1));
        send(make_cmd(CMD_W'(CMD_UNUSED_LO + 1), '0, '0, '0));
        send(make_cmd(CMD_UNUSED_HI, '1, '1, '1));
        send(make_cmd(CMD_CLEAR,  '0, '0, '0));
        send(make_cmd(CMD_READ,   '0, '1, '0));
        send(make_cmd(CMD_QUERY,  '1, '0, '0));
        send(make_cmd(CMD_MERGE,  '0, 12'd2, 64'h0123_4567_89AB_CDEF));

        // smallest filter: one block, word index four onwards is out of range
        drain_and_configure(4'd0);
        send(make_cmd(CMD_MERGE,  '0, 12'd4, '1));
        send(make_cmd(CMD_READ,   '0, '1, '0));
        send(make_cmd(CMD_INSERT, '1, '0, '0));
        send(make_cmd(CMD_QUERY,  64'hFFFF_FFFF_0000_1234, '0, '0));
        send(make_cmd(CMD_READ,   '0, 12'd3, '0));

        // register above the maximum saturates
        drain_and_configure(4'd15);
        send(make_cmd(CMD_READ,   '0, '1, '0));

        foreach (phase_log[p]) begin
            drain_and_configure(phase_log[p]);
            random_phase(200);
        end

        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("ran %0d transactions across %0d register settings, %0d results checked",
                 sent, settings, sb.checked);
        $display("%0d query hits, %0d out-of-range accesses, %0d clears",
                 sb.hits, sb.range_errors, sb.clears);
        if (sb.errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
